>>> design/zpt_pkg.sv
// Shared types and constants for the zigzag pivot tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package zpt_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned TrendW   = ValW + 1;
  localparam int unsigned CntW     = 16;
  localparam int unsigned InDataW  = TimeW + ValW;
  localparam int unsigned OutDataW = ((TrendW + CntW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - TrendW - CntW;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Item function codes
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_e;

  // One input word as held in the input stage
  typedef struct packed {
    func_e                   func;
    logic [TimeW-1:0]        sample_time;
    logic signed [ValW-1:0]  sample_value;
  } item_t;

  // One result word
  typedef struct packed {
    logic signed [TrendW-1:0] trend;
    logic [CntW-1:0]          pivot_count;
  } result_t;

endpackage : zpt_pkg

`default_nettype wire

>>> design/zpt_in_reg.sv
// Input stage: holds one accepted word until the tracker core takes it.
// Depends on zpt_pkg.
`default_nettype none

module zpt_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire zpt_pkg::item_t in_item_i,
  output logic               item_valid_o,
  output zpt_pkg::item_t     item_o,
  input  wire logic          take_i
);
  import zpt_pkg::*;

  logic  valid_q;
  item_t item_q;

  // Accept whenever the stage is empty or its word leaves this cycle
  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule : zpt_in_reg

`default_nettype wire

>>> design/zpt_core.sv
// Pivot state, configuration register and combinational next-state update of the zigzag.
// Depends on zpt_pkg.
`default_nettype none

module zpt_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [zpt_pkg::TimeW-1:0] cfg_data_i,
  input  wire logic                     take_i,
  input  wire zpt_pkg::item_t            item_i,
  output zpt_pkg::result_t               result_o
);
  import zpt_pkg::*;

  logic [TimeW-1:0]       min_leg_time_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [ValW-1:0] ov_q, ov_d;
  logic [TimeW-1:0]       lt_q, lt_d;
  logic signed [ValW-1:0] lv_q, lv_d;
  logic [TimeW-1:0]       pt_q, pt_d;
  logic signed [ValW-1:0] pv_q, pv_d;

  logic [TimeW-1:0]       t;
  logic signed [ValW-1:0] v;
  logic [TimeW+1:0]       leg_end;
  logic                   promote;
  logic signed [TrendW-1:0] diff;

  assign cfg_ready_o = 1'b1;
  assign t = item_i.sample_time;
  assign v = item_i.sample_value;

  // Promote once the pending point lies far enough past the last pivot
  assign leg_end = {2'b00, lt_q} + {2'b00, min_leg_time_q};
  assign promote = {2'b00, pt_q} >= leg_end;

  // Next pivot state for the word in the input stage
  always_comb begin
    cnt_d = cnt_q;
    ov_d  = ov_q;
    lt_d  = lt_q;
    lv_d  = lv_q;
    pt_d  = pt_q;
    pv_d  = pv_q;
    if (item_i.func == FUNC_CLEAR) begin
      cnt_d = '0;
    end else if (cnt_q == '0) begin
      lt_d  = t;
      lv_d  = v;
      pt_d  = t;
      pv_d  = v;
      cnt_d = CntW'(1);
    end else if (pv_q != v) begin
      // Pending point becomes a pivot
      if (promote) begin
        ov_d  = lv_q;
        lt_d  = pt_q;
        lv_d  = pv_q;
        cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
        pt_d  = t;
        pv_d  = v;
      end
      // Extend the leg
      if (cnt_d == CntW'(1)) begin
        if (lv_d < pv_d) begin
          if (pv_d < v) begin
            pt_d = t;
            pv_d = v;
          end else if (lv_d > v) begin
            lv_d = pv_d;
            pt_d = t;
            pv_d = v;
          end
        end else if (lv_d > pv_d) begin
          if (pv_d > v) begin
            pt_d = t;
            pv_d = v;
          end else if (lv_d < v) begin
            lv_d = pv_d;
            pt_d = t;
            pv_d = v;
          end
        end else if (pv_d != v) begin
          pt_d = t;
          pv_d = v;
        end
      end else if (ov_d < lv_d) begin
        if (lv_d < pv_d) begin
          lt_d = pt_d;
          lv_d = pv_d;
        end else if (pv_d > v) begin
          pt_d = t;
          pv_d = v;
        end else if (lv_d < v) begin
          pt_d = t;
          pv_d = v;
          lt_d = t;
          lv_d = v;
        end
      end else begin
        if (lv_d > pv_d) begin
          lt_d = pt_d;
          lv_d = pv_d;
        end else if (pv_d < v) begin
          pt_d = t;
          pv_d = v;
        end else if (lv_d > v) begin
          pt_d = t;
          pv_d = v;
          lt_d = t;
          lv_d = v;
        end
      end
    end
  end

  // Leg difference of the updated pivots
  assign diff = {lv_d[ValW-1], lv_d} - {ov_d[ValW-1], ov_d};
  assign result_o.trend       = (cnt_d < CntW'(2)) ? '0 : diff;
  assign result_o.pivot_count = cnt_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_leg_time_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_leg_time_q <= cfg_data_i;
    end
  end

  // Advance the pivot state on each word taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= '0;
      lt_q  <= '0;
      lv_q  <= '0;
      pt_q  <= '0;
      pv_q  <= '0;
    end else if (take_i) begin
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      lt_q  <= lt_d;
      lv_q  <= lv_d;
      pt_q  <= pt_d;
      pv_q  <= pv_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_zeroes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.func == FUNC_CLEAR |=> cnt_q == '0)
    else $error("pivot count not cleared");

  a_first_sample_is_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.func == FUNC_SAMPLE && cnt_q == '0 |=>
      cnt_q == CntW'(1) && lv_q == pv_q && lt_q == pt_q)
    else $error("first sample did not seed the pivot list");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.func == FUNC_SAMPLE |=> cnt_q >= $past(cnt_q))
    else $error("pivot count dropped without a clear");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> $stable(cnt_q) && $stable(lv_q) && $stable(pv_q) && $stable(ov_q))
    else $error("pivot state moved without a word");
`endif

endmodule : zpt_core

`default_nettype wire

>>> design/zpt_out_reg.sv
// Result register: holds one result word for the output channel and
// decides when the core may take the next input word. Depends on zpt_pkg.
`default_nettype none

module zpt_out_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire zpt_pkg::result_t result_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output zpt_pkg::result_t      result_o
);
  import zpt_pkg::*;

  logic    valid_q;
  result_t result_q;

  // Take a word when the result slot is free or drains this cycle
  assign take_o      = item_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_i;
    end
  end

endmodule : zpt_out_reg

`default_nettype wire

>>> design/zigzag_pivot_tracker_top.sv
// Top level of the zigzag pivot tracker: stream ports and stage wiring.
// Depends on zpt_pkg, zpt_in_reg, zpt_core and zpt_out_reg.
`default_nettype none

// Follows price pivots in a stream of timestamped samples and returns, for
// every input word, one result word with the latest leg difference and the
// saturating pivot count. While the result side is ready, one word is taken
// per clock cycle. An input word passes the input register and then the
// result register before its result word is valid. A stalled result side
// first fills the result register, then the input register, and then drops
// s_axis_tready. The rate is set by the pivot state update, which is
// combinational, so the next word sees the registered state at once.
// min_leg_time is written on the configuration channel, which is always
// ready; write it only while no word is in flight.
module zigzag_pivot_tracker_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: min_leg_time
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [zpt_pkg::TimeW-1:0]      cfg_data_i,
  // Input words
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [zpt_pkg::InDataW-1:0]    s_axis_tdata,  // [31:0] sample_time, [63:32] sample_value
  input  wire logic                          s_axis_tuser,  // [0] func
  // Result words
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [zpt_pkg::OutDataW-1:0]        m_axis_tdata   // [32:0] trend, [48:33] pivot_count
);
  import zpt_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t core_result;
  result_t out_result;

  // Unpack the input word
  assign in_item.func         = func_e'(s_axis_tuser);
  assign in_item.sample_time  = s_axis_tdata[TimeW-1:0];
  assign in_item.sample_value = s_axis_tdata[InDataW-1:TimeW];

  zpt_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .item_valid_o(item_valid),
    .item_o      (item),
    .take_i      (take)
  );

  zpt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .item_i     (item),
    .result_o   (core_result)
  );

  zpt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .result_i    (core_result),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  // Pack the result word
  assign m_axis_tdata = {{OutPadW{1'b0}}, out_result.pivot_count, out_result.trend};

endmodule : zigzag_pivot_tracker_top

`default_nettype wire

>>> sim/tb_zigzag_pivot_tracker_top.sv
// Self-checking testbench for zigzag_pivot_tracker_top: directed words, random legs, long stall.
// Depends on zpt_pkg and the RTL; result words are checked against a predictor or typed results.
`timescale 1ns / 1ps

module tb_zigzag_pivot_tracker_top;
  import zpt_pkg::*;

  localparam int ClkHalf     = 10;
  localparam int GapMax      = 18;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 300;

  // One row of the directed plan: a config write or a word, with an optional typed result
  typedef struct {
    bit               is_cfg;
    func_e            fn;
    logic [TimeW-1:0] t;
    logic [ValW-1:0]  v;
    bit               fixed;
    logic [CntW-1:0]  cnt;
  } plan_row_t;

  typedef struct packed {
    logic    fixed;
    result_t res;
  } typed_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic [TimeW-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_ready_o;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predictor state
  logic [31:0]      zz_count;
  longint           zz_older, zz_last, zz_pend;
  logic [TimeW-1:0] zz_last_t, zz_pend_t, zz_leg;

  typed_t  typed_q[$];
  result_t leg_results_q[$];

  logic [TimeW-1:0] cur_leg;
  bit tx_gaps;
  bit rx_gaps;
  int rx_hold;
  int n_err, n_words, n_clears, n_results, n_cfg;
  logic [31:0] peak_count;

  zigzag_pivot_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] sample_time, [63:32] sample_value
    .s_axis_tuser  (s_axis_tuser),   // [0] func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [32:0] trend, [48:33] pivot_count
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Advance the pivot state by one word and return the leg difference and count
  task automatic advance_zigzag(input func_e fn, input logic [TimeW-1:0] t,
                                input logic signed [ValW-1:0] sv, output result_t res);
    longint v;
    longint span;
    logic signed [63:0] diff;
    v = longint'(sv);
    if (fn == FUNC_CLEAR) begin
      zz_count = 0;
    end else if (zz_count == 0) begin
      zz_last_t = t; zz_last = v;
      zz_pend_t = t; zz_pend = v;
      zz_count  = 1;
    end else if (zz_pend != v) begin
      // promote the pending point once it sits far enough past the last pivot
      span = longint'({32'd0, zz_pend_t}) - longint'({32'd0, zz_last_t});
      if (span >= longint'({32'd0, zz_leg})) begin
        zz_older  = zz_last;
        zz_last_t = zz_pend_t;
        zz_last   = zz_pend;
        if (zz_count < CntMax) zz_count++;
        zz_pend_t = t; zz_pend = v;
      end
      // extend the current leg
      if (zz_count == 1) begin
        if (zz_last < zz_pend) begin
          if (zz_pend < v) begin
            zz_pend_t = t; zz_pend = v;
          end else if (zz_last > v) begin
            zz_last = zz_pend;
            zz_pend_t = t; zz_pend = v;
          end
        end else if (zz_last > zz_pend) begin
          if (zz_pend > v) begin
            zz_pend_t = t; zz_pend = v;
          end else if (zz_last < v) begin
            zz_last = zz_pend;
            zz_pend_t = t; zz_pend = v;
          end
        end else if (zz_pend != v) begin
          zz_pend_t = t; zz_pend = v;
        end
      end else if (zz_older < zz_last) begin
        if (zz_last < zz_pend) begin
          zz_last_t = zz_pend_t; zz_last = zz_pend;
        end else if (zz_pend > v) begin
          zz_pend_t = t; zz_pend = v;
        end else if (zz_last < v) begin
          zz_pend_t = t; zz_pend = v;
          zz_last_t = t; zz_last = v;
        end
      end else begin
        if (zz_last > zz_pend) begin
          zz_last_t = zz_pend_t; zz_last = zz_pend;
        end else if (zz_pend < v) begin
          zz_pend_t = t; zz_pend = v;
        end else if (zz_last > v) begin
          zz_pend_t = t; zz_pend = v;
          zz_last_t = t; zz_last = v;
        end
      end
    end
    diff = zz_last - zz_older;
    res.pivot_count = zz_count[CntW-1:0];
    res.trend = (zz_count < 2) ? '0 : diff[TrendW-1:0];
  endtask

  // Predict on accepted words, check accepted result words
  always @(posedge clk_i) begin : scoreboard
    typed_t  tag;
    result_t want;
    result_t got;
    if (cfg_valid_i && cfg_ready_o) begin
      zz_leg = cfg_data_i;
      n_cfg++;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      tag = typed_q.pop_front();
      advance_zigzag(func_e'(s_axis_tuser), s_axis_tdata[TimeW-1:0],
                     s_axis_tdata[InDataW-1:TimeW], want);
      if (tag.fixed) want = tag.res;
      leg_results_q.push_back(want);
      if (zz_count > peak_count) peak_count = zz_count;
      n_words++;
      if (s_axis_tuser == FUNC_CLEAR) n_clears++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.trend       = m_axis_tdata[TrendW-1:0];
      got.pivot_count = m_axis_tdata[TrendW +: CntW];
      n_results++;
      if (leg_results_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result word, trend %0d count %0d",
                 $time, got.trend, got.pivot_count);
      end else begin
        want = leg_results_q.pop_front();
        if (got.trend !== want.trend) begin
          n_err++;
          $display("%0t: trend mismatch, expected %0d actual %0d",
                   $time, want.trend, got.trend);
        end
        if (got.pivot_count !== want.pivot_count) begin
          n_err++;
          $display("%0t: pivot_count mismatch, expected %0d actual %0d",
                   $time, want.pivot_count, got.pivot_count);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      stall = rx_gaps ? $urandom_range(0, GapMax) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic offer_word(input func_e fn, input logic [TimeW-1:0] t,
                            input logic [ValW-1:0] v, input bit fixed, input result_t res);
    typed_t tag;
    int gap;
    tag.fixed = fixed;
    tag.res   = res;
    typed_q.push_back(tag);
    gap = tx_gaps ? $urandom_range(0, GapMax) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, t};
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every expected result word has arrived
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (leg_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_min_leg(input logic [TimeW-1:0] leg);
    settle();
    cur_leg = leg;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= leg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed legs: rising or falling walks with time steps near the minimum leg time
  task automatic run_phase(input int n_items);
    logic [TimeW-1:0] t;
    logic [ValW-1:0]  v;
    logic [ValW-1:0]  delta;
    int pick;
    bit rising;
    t = $urandom;
    v = $urandom;
    rising = $urandom_range(0, 1);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        offer_word(FUNC_CLEAR, $urandom, $urandom, 1'b0, '0);
      end else if (pick < 12) begin
        offer_word(FUNC_SAMPLE, $urandom, $urandom, 1'b0, '0);
      end else begin
        case ($urandom_range(0, 5))
          0: t = t;
          1, 2: t += $urandom_range(1, 16);
          3: t += cur_leg >> 1;
          4: t += cur_leg;
          default: t += cur_leg + $urandom_range(1, 3);
        endcase
        if ($urandom_range(0, 3) == 0) rising = !rising;
        pick = $urandom_range(0, 9);
        if (pick == 1) begin
          v = $urandom;
        end else if (pick != 0) begin
          delta = $urandom_range(1, 40);
          v = rising ? v + delta : v - delta;
        end
        offer_word(FUNC_SAMPLE, t, v, 1'b0, '0);
      end
    end
  endtask

  function automatic plan_row_t plan_row(bit is_cfg, func_e fn, logic [TimeW-1:0] t,
                                         logic [ValW-1:0] v, bit fixed, logic [CntW-1:0] cnt);
    plan_row_t r;
    r.is_cfg = is_cfg;
    r.fn     = fn;
    r.t      = t;
    r.v      = v;
    r.fixed  = fixed;
    r.cnt    = cnt;
    return r;
  endfunction

  initial begin : stimulus
    plan_row_t   plan[$];
    result_t     typed_res;
    logic [31:0] legs[8];
    int k;

    zz_count = 0; zz_older = 0; zz_last = 0; zz_pend = 0;
    zz_last_t = '0; zz_pend_t = '0; zz_leg = '0;
    cur_leg = '0; peak_count = 0;
    tx_gaps = 1'b1; rx_gaps = 1'b1; rx_hold = 0;
    n_err = 0; n_words = 0; n_clears = 0; n_results = 0; n_cfg = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, time going back, single-pivot pulls with promotion blocked, then a leg time of 1
    plan.push_back(plan_row(0, FUNC_CLEAR,  0,            0,            1, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 0,            32'h8000_0000, 1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 0,            32'h8000_0000, 1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 5,            32'h7FFF_FFFF, 0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 10,           32'h8000_0000, 0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 15,           32'h7FFF_FFFF, 0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 32'hFFFF_FFFF, 0,            0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 3,            7,            0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 4,            -7,           0, 0));
    plan.push_back(plan_row(0, FUNC_CLEAR,  0,            0,            1, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 20,           3,            1, 1));
    plan.push_back(plan_row(1, FUNC_SAMPLE, 0,            32'hFFFF_FFFF, 0, 0));
    plan.push_back(plan_row(0, FUNC_CLEAR,  0,            0,            1, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 10,           100,          1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 20,           150,          1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 30,           200,          1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 40,           50,           1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 50,           30,           1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 60,           250,          1, 1));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 70,           250,          1, 1));
    plan.push_back(plan_row(1, FUNC_SAMPLE, 0,            1,            0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 71,           40,           0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 72,           20,           0, 0));
    plan.push_back(plan_row(0, FUNC_SAMPLE, 73,           300,          0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_min_leg(plan[i].v);
      end else begin
        typed_res.trend       = '0;
        typed_res.pivot_count = plan[i].cnt;
        offer_word(plan[i].fn, plan[i].t, plan[i].v, plan[i].fixed, typed_res);
      end
    end

    // Random legs under a spread of minimum leg times
    legs[0] = 0;
    legs[1] = 1;
    legs[2] = $urandom_range(2, 40);
    legs[3] = $urandom_range(100, 5000);
    legs[4] = 32'h7FFF_FFFF;
    legs[5] = 32'hFFFF_FFFF;
    legs[6] = $urandom;
    legs[7] = $urandom_range(0, 8);
    for (k = 0; k < 8; k++) begin
      set_min_leg(legs[k]);
      tx_gaps = (k == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_gaps = (k == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_phase(135);
      if (k == 4) begin
        // hold the result side off while words keep coming
        rx_hold = HoldCycles;
        tx_gaps = 1'b0;
        run_phase(60);
      end
    end

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_phase(20);
    offer_word(FUNC_CLEAR, $urandom, $urandom, 1'b1, '0);

    settle();
    $display("Run covered %0d words (%0d clears) and %0d checked results under %0d",
             n_words, n_clears, n_results, n_cfg);
    $display("min_leg_time settings; peak pivot count reached %0d.", peak_count);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    #(20_000_000);
    $display("Timeout with %0d result words outstanding", leg_results_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
